// ----- design/oms_pkg.sv -----
`default_nettype none
package oms_pkg;

    // Line store depth and the position width that follows from it.
    localparam int LINE_MAX = 2048;
    localparam int POS_W = $clog2(LINE_MAX);
    localparam int LEN_W = POS_W + 1;

    // Overscan sample store depth and its count width.
    localparam int OVS_MAX = 64;
    localparam int OVS_IDX_W = $clog2(OVS_MAX);
    localparam int OVS_CNT_W = OVS_IDX_W + 1;

    localparam int PIX_W = 16;
    localparam int MED_W = PIX_W + 1;
    localparam int CORR_W = PIX_W + 2;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_LINE_LENGTH = 3'd0;
    localparam logic [2:0] REG_OVS_START = 3'd1;
    localparam logic [2:0] REG_OVS_END = 3'd2;
    localparam logic [2:0] REG_EFF_START = 3'd3;
    localparam logic [2:0] REG_EFF_END = 3'd4;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Control from the top level to the sample sorter.
    typedef struct packed {
        logic ins_valid;
        logic clear;
    } srt_ctrl_t;

    // One result item waiting in the output queue.
    typedef struct packed {
        logic [CORR_W-1:0] corrected_value;
        logic in_window;
        logic [POS_W-1:0] pixel_position;
        logic line_done;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_MEDIAN = 2'b10
    } oms_state_t;

endpackage
`default_nettype wire

// ----- design/oms_sorter.sv -----
`default_nettype none
// Keeps the overscan samples of the current line in ascending order.
// Each new sample is placed by a row of compare cells, so the median is a
// plain selection of the one or two middle entries.
module oms_sorter
    import oms_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire srt_ctrl_t ctrl,
    input wire logic [PIX_W-1:0] ins_value,
    output logic [MED_W-1:0] median
);

    logic [PIX_W-1:0] s_reg [OVS_MAX];
    logic [OVS_CNT_W-1:0] count_reg;
    logic [OVS_CNT_W-1:0] count_next;
    logic [OVS_MAX-1:0] le_vec;
    logic insert;
    logic [OVS_IDX_W-1:0] hi_idx;
    logic [OVS_IDX_W-1:0] lo_idx;

    assign insert = ctrl.ins_valid && (count_reg < OVS_CNT_W'(OVS_MAX));

    // A cell below the fill count whose value is not above the new sample
    // keeps its place; the set of such cells is a prefix of the row.
    always_comb
    begin
        for (int i = 0; i < OVS_MAX; i++)
        begin
            le_vec[i] = (OVS_CNT_W'(i) < count_reg) && (s_reg[i] <= ins_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            for (int i = 0; i < OVS_MAX; i++)
            begin
                if (!le_vec[i])
                begin
                    if (i == 0)
                    begin
                        s_reg[i] <= ins_value;
                    end
                    else if (le_vec[i-1])
                    begin
                        s_reg[i] <= ins_value;
                    end
                    else
                    begin
                        s_reg[i] <= s_reg[i-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (insert)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Median in half counts: twice the middle entry for an odd count, the
    // sum of the two middle entries for an even one.
    assign hi_idx = OVS_IDX_W'(count_reg >> 1);
    assign lo_idx = hi_idx - 1'b1;

    always_comb
    begin
        if (count_reg == '0)
        begin
            median = '0;
        end
        else if (count_reg[0])
        begin
            median = {s_reg[hi_idx], 1'b0};
        end
        else
        begin
            median = MED_W'(s_reg[lo_idx]) + MED_W'(s_reg[hi_idx]);
        end
    end

endmodule
`default_nettype wire

// ----- design/overscan_median_subtract.sv -----
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  opcode, pixel_value, line_end
// output    out        out_valid/out_stall  corrected_value, in_window,
//                                           pixel_position, line_done
// config    in         APB write/read       five window and length registers
//
// An input transfer that completes a line is followed by a median state
// in which the median is latched from the sorted sample row and no input
// is taken. A result passes through the line store read register and is
// then subtracted on its way into the output queue. A four-entry output
// queue absorbs output stalls; input stall rises when the queue and
// the subtraction stage together could not hold another result. Reset
// clears all control state; the line store has no reset.
module overscan_median_subtract
    import oms_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,

    input wire logic in_valid,
    output logic in_stall,
    input wire logic opcode,
    input wire logic [PIX_W-1:0] pixel_value,
    input wire logic line_end,

    output logic out_valid,
    input wire logic out_stall,
    output logic signed [CORR_W-1:0] corrected_value,
    output logic in_window,
    output logic [POS_W-1:0] pixel_position,
    output logic line_done,

    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [4:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    // Configuration registers.
    logic [LEN_W-1:0] line_length_reg;
    logic [POS_W-1:0] ovs_start_reg;
    logic [POS_W-1:0] ovs_end_reg;
    logic [POS_W-1:0] eff_start_reg;
    logic [POS_W-1:0] eff_end_reg;
    logic cfg_wr;
    logic [2:0] cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LEN_W'(LINE_MAX);
            ovs_start_reg <= '0;
            ovs_end_reg <= '0;
            eff_start_reg <= '0;
            eff_end_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LINE_LENGTH: line_length_reg <= pwdata[LEN_W-1:0];
                REG_OVS_START: ovs_start_reg <= pwdata[POS_W-1:0];
                REG_OVS_END: ovs_end_reg <= pwdata[POS_W-1:0];
                REG_EFF_START: eff_start_reg <= pwdata[POS_W-1:0];
                REG_EFF_END: eff_end_reg <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LINE_LENGTH: prdata = 32'(line_length_reg);
            REG_OVS_START: prdata = 32'(ovs_start_reg);
            REG_OVS_END: prdata = 32'(ovs_end_reg);
            REG_EFF_START: prdata = 32'(eff_start_reg);
            REG_EFF_END: prdata = 32'(eff_end_reg);
            default: prdata = '0;
        endcase
    end

    // Sequencing state.
    oms_state_t state_reg;
    oms_state_t state_next;
    logic [POS_W-1:0] write_pos_reg;
    logic [POS_W-1:0] read_pos_reg;
    logic [POS_W-1:0] stored_last_reg;
    logic line_ready_reg;
    logic [MED_W-1:0] median_reg;

    logic accept;
    logic emit;
    logic store;
    logic emit_done;
    logic emit_win;
    logic [LEN_W-1:0] len_eff;
    logic line_complete;
    logic sample_hit;

    // Subtraction stage and output queue.
    logic s1_valid_reg;
    logic s1_win_reg;
    logic s1_done_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic [PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0] line_mem [LINE_MAX];

    out_item_t fifo_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] occ_reg;
    logic push;
    logic pop;
    out_item_t push_item;
    logic signed [CORR_W-1:0] corr;

    srt_ctrl_t srt_ctrl;
    logic [MED_W-1:0] srt_median;

    // Input is held off while the median is latched, and while the queue
    // plus the result in flight fill all four entries.
    assign in_stall = (state_reg == ST_MEDIAN) || ((occ_reg + 3'(s1_valid_reg)) > 3'd3);
    assign accept = in_valid && !in_stall;
    assign emit = accept && line_ready_reg;
    assign store = accept && (opcode == OP_STORE);

    assign emit_done = read_pos_reg >= stored_last_reg;
    assign emit_win = ((read_pos_reg >= eff_start_reg) && (read_pos_reg <= eff_end_reg))
                   || ((read_pos_reg >= ovs_start_reg) && (read_pos_reg <= ovs_end_reg));

    // A line ends on line_end, at the configured length (zero acts as one),
    // or at the end of the store.
    always_comb
    begin
        if (line_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (line_length_reg > LEN_W'(LINE_MAX))
        begin
            len_eff = LEN_W'(LINE_MAX);
        end
        else
        begin
            len_eff = line_length_reg;
        end
    end

    assign line_complete = line_end || ((LEN_W'(write_pos_reg) + 1'b1) >= len_eff);
    assign sample_hit = (write_pos_reg >= ovs_start_reg) && (write_pos_reg <= ovs_end_reg);

    assign srt_ctrl.ins_valid = store && sample_hit;
    assign srt_ctrl.clear = (state_reg == ST_MEDIAN);

    oms_sorter u_sorter (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(srt_ctrl),
        .ins_value(pixel_value),
        .median(srt_median)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (store && line_complete)
                begin
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN: state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    // The stored line is read before the new pixel is written. The read
    // position never trails the write position, so no unread pixel of the
    // stored line is overwritten. A completing store replaces the stored
    // line, whatever the emit side did in the same transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            write_pos_reg <= '0;
            read_pos_reg <= '0;
            stored_last_reg <= '0;
            line_ready_reg <= 1'b0;
            median_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MEDIAN)
            begin
                median_reg <= srt_median;
            end
            if (store && line_complete)
            begin
                stored_last_reg <= write_pos_reg;
                read_pos_reg <= '0;
                line_ready_reg <= 1'b1;
                write_pos_reg <= '0;
            end
            else
            begin
                if (store)
                begin
                    write_pos_reg <= write_pos_reg + 1'b1;
                end
                if (emit)
                begin
                    if (emit_done)
                    begin
                        line_ready_reg <= 1'b0;
                        read_pos_reg <= '0;
                    end
                    else
                    begin
                        read_pos_reg <= read_pos_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            line_mem[write_pos_reg] <= pixel_value;
        end
        if (emit)
        begin
            rd_data_reg <= line_mem[read_pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_win_reg <= emit_win;
            s1_done_reg <= emit_done;
            s1_pos_reg <= read_pos_reg;
        end
    end

    // The median register still holds the stored line's value here: a new
    // median is latched only in the median state after the completing transfer.
    assign corr = s1_win_reg
                ? ($signed({1'b0, rd_data_reg, 1'b0}) - $signed({1'b0, median_reg}))
                : '0;

    assign push = s1_valid_reg;
    assign pop = out_valid && !out_stall;
    assign push_item.corrected_value = corr;
    assign push_item.in_window = s1_win_reg;
    assign push_item.pixel_position = s1_pos_reg;
    assign push_item.line_done = s1_done_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            occ_reg <= occ_reg + 3'(push) - 3'(pop);
        end
    end

    assign out_valid = (occ_reg != '0);
    assign corrected_value = $signed(fifo_reg[rd_ptr_reg].corrected_value);
    assign in_window = fifo_reg[rd_ptr_reg].in_window;
    assign pixel_position = fifo_reg[rd_ptr_reg].pixel_position;
    assign line_done = fifo_reg[rd_ptr_reg].line_done;

    // The output queue never holds more than its four entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'd4)
        else $error("output queue overflow");

    // The median state gives way to the run state in the next cycle and takes no input transfer.
    a_median_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEDIAN) |=> (state_reg == ST_RUN))
        else $error("median latch longer than one cycle");

    a_no_accept_in_median: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEDIAN) |-> !accept)
        else $error("input taken while median latched");

    // A completing transfer always leaves a stored line to emit.
    a_line_ready_after_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (store && line_complete) |=> line_ready_reg)
        else $error("completed line not marked ready");

    // Writing never runs ahead of reading within a stored line.
    a_read_not_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (line_ready_reg && (state_reg == ST_RUN)) |-> (read_pos_reg >= write_pos_reg))
        else $error("line store write passed the read position");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import oms_pkg::*;

    // One emitted pixel as the block presents it on its output channel.
    typedef struct {
        logic signed [CORR_W-1:0] corr;
        logic win;
        logic [POS_W-1:0] pos;
        logic done;
    } pixel_out_t;

    // One row of the directed table. Rows marked as typed carry their result
    // by hand; all other rows are checked against the line model below.
    typedef struct {
        logic op;
        logic [PIX_W-1:0] pix;
        logic le;
        bit typed;
        bit has_res;
        pixel_out_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = OP_STORE;
    logic [PIX_W-1:0] pixel_value = '0;
    logic line_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [CORR_W-1:0] corrected_value;
    logic in_window;
    logic [POS_W-1:0] pixel_position;
    logic line_done;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    overscan_median_subtract dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .pixel_value(pixel_value),
        .line_end(line_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .corrected_value(corrected_value),
        .in_window(in_window),
        .pixel_position(pixel_position),
        .line_done(line_done),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 clk = ~clk;

    // Line model state: register copies, the stored line, the overscan
    // samples of the line being written, and the read and write pointers.
    int unsigned len_reg = 2048;
    int unsigned ovs_lo = 0;
    int unsigned ovs_hi = 0;
    int unsigned eff_lo = 0;
    int unsigned eff_hi = 0;
    logic [PIX_W-1:0] line_mem [LINE_MAX];
    logic [PIX_W-1:0] ovs_samples [OVS_MAX];
    int unsigned ovs_count = 0;
    int unsigned line_median = 0;
    int unsigned wr_pos = 0;
    int unsigned rd_pos = 0;
    int unsigned stored_last = 0;
    bit line_pending = 0;

    pixel_out_t pending_pixels [$];
    int mismatches = 0;
    // While calm is set, neither side inserts gaps or stalls.
    bit calm = 0;

    // Median of the collected overscan samples in half counts.
    function automatic int unsigned overscan_median();
        int sorted [$];
        int n;
        n = ovs_count;
        if (n == 0)
            return 0;
        for (int i = 0; i < n; i++)
            sorted.push_back(ovs_samples[i]);
        sorted.sort();
        if (n % 2 == 1)
            return 2 * sorted[n / 2];
        return sorted[n / 2 - 1] + sorted[n / 2];
    endfunction

    // Advance the line model by one accepted transfer. Returns 1 when the
    // transfer makes the block emit a pixel of the stored line.
    function automatic bit advance_line(input logic op, input logic [PIX_W-1:0] pix,
                                        input logic le, output pixel_out_t r);
        bit made;
        bit win;
        int corr;
        int unsigned p;
        int unsigned w;
        int unsigned len;
        made = 0;
        r = '{default: '0};
        // The stored pixel is read before the new one is written.
        if (line_pending) begin
            p = rd_pos;
            win = (p >= eff_lo && p <= eff_hi) || (p >= ovs_lo && p <= ovs_hi);
            corr = win ? 2 * int'(line_mem[p]) - int'(line_median) : 0;
            r.corr = corr[CORR_W-1:0];
            r.win = win;
            r.pos = p[POS_W-1:0];
            r.done = (p >= stored_last);
            made = 1;
            if (r.done) begin
                line_pending = 0;
                rd_pos = 0;
            end
            else
                rd_pos = p + 1;
        end
        if (op == OP_STORE) begin
            len = (len_reg == 0) ? 1 : len_reg;
            if (len > LINE_MAX)
                len = LINE_MAX;
            w = wr_pos;
            line_mem[w] = pix;
            if (w >= ovs_lo && w <= ovs_hi && ovs_count < OVS_MAX) begin
                ovs_samples[ovs_count] = pix;
                ovs_count++;
            end
            // A completed line replaces the stored one, even if that one
            // has not been fully emitted yet.
            if (le || w + 1 >= len) begin
                line_median = overscan_median();
                ovs_count = 0;
                stored_last = w;
                rd_pos = 0;
                line_pending = 1;
                wr_pos = 0;
            end
            else
                wr_pos = w + 1;
        end
        return made;
    endfunction

    // Write a register over the APB port, then read it back. The setup and
    // access phases of both accesses follow in order; pready is expected high throughout.
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        logic [31:0] mask;
        mask = (idx == REG_LINE_LENGTH) ? 32'hFFF : 32'h7FF;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== (value & mask)) begin
            $error("register %0d readback: expected %0h, got %0h", idx, value & mask, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LINE_LENGTH: len_reg = value & mask;
            REG_OVS_START: ovs_lo = value & mask;
            REG_OVS_END: ovs_hi = value & mask;
            REG_EFF_START: eff_lo = value & mask;
            default: eff_hi = value & mask;
        endcase
    endtask

    task automatic configure(input int unsigned len, input int unsigned olo,
                             input int unsigned ohi, input int unsigned elo,
                             input int unsigned ehi);
        write_reg(REG_LINE_LENGTH, len);
        write_reg(REG_OVS_START, olo);
        write_reg(REG_OVS_END, ohi);
        write_reg(REG_EFF_START, elo);
        write_reg(REG_EFF_END, ehi);
    endtask

    // Offer one input transfer after a random gap and hold it until taken.
    // The expected pixel, if any, is queued at the edge of the transfer.
    task automatic send_pixel(input logic op, input logic [PIX_W-1:0] pix, input logic le,
                              input bit typed, input bit has_res, input pixel_out_t tres);
        int gap;
        bit made;
        pixel_out_t r;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode <= op;
        pixel_value <= pix;
        line_end <= le;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        made = advance_line(op, pix, le, r);
        if (typed) begin
            if (has_res)
                pending_pixels.push_back(tres);
        end
        else if (made)
            pending_pixels.push_back(r);
        @(negedge clk);
    endtask

    // Let the block empty out so that registers can change safely. Transfers
    // that emit nothing may still be in flight, so it idles on after the expected pixels are out.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Random pixel with a strong bias toward the two extremes.
    function automatic logic [PIX_W-1:0] rand_pixel();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PIX_W'($urandom_range(0, 65535));
    endfunction

    // One random phase: drains and stores with random line ends.
    task automatic random_phase(input int count, input int drain_pct, input int end_pct);
        pixel_out_t none;
        logic op;
        none = '{default: '0};
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 99) < drain_pct) ? OP_DRAIN : OP_STORE;
            send_pixel(op, rand_pixel(), $urandom_range(0, 99) < end_pct, 0, 0, none);
        end
        calm = 0;
    endtask

    // Directed table, run with the registers as reset leaves them: lines of
    // 2048 pixels and both windows covering position zero alone.
    stim_row_t directed [] = '{
        // Drain with no stored line: nothing comes out.
        '{OP_DRAIN, 16'h1234, 1'b0, 1, 0, '{0, 0, 0, 0}},
        // A one-pixel line at full scale sets the median to 131070.
        '{OP_STORE, 16'hFFFF, 1'b1, 0, 0, '{0, 0, 0, 0}},
        // Its only pixel is its own overscan sample, so it comes out as zero.
        '{OP_STORE, 16'h0000, 1'b1, 1, 1, '{18'sd0, 1'b1, 11'd0, 1'b1}},
        '{OP_DRAIN, 16'hFFFF, 1'b1, 1, 1, '{18'sd0, 1'b1, 11'd0, 1'b1}},
        '{OP_DRAIN, 16'h0000, 1'b0, 1, 0, '{0, 0, 0, 0}},
        // A three-pixel line, drained; drain items ignore the line end mark.
        '{OP_STORE, 16'hFFFF, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_STORE, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_STORE, 16'h0007, 1'b1, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b1, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        // Another three-pixel line; a one-pixel line completes early and
        // the rest of the stored line is dropped.
        '{OP_STORE, 16'h8000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_STORE, 16'h7FFF, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_STORE, 16'h0001, 1'b1, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_STORE, 16'h0100, 1'b1, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}},
        '{OP_DRAIN, 16'h0000, 1'b0, 0, 0, '{0, 0, 0, 0}}
    };

    // Output side: draw a stall for each result, then compare it with the
    // oldest expectation at the edge where the transfer completes.
    initial begin
        int hold;
        pixel_out_t want;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1));
            if (pending_pixels.size() == 0) begin
                $error("unexpected transfer at position %0d", pixel_position);
                mismatches++;
            end
            else begin
                want = pending_pixels.pop_front();
                if (corrected_value !== want.corr) begin
                    $error("corrected_value: expected %0d, got %0d", want.corr,
                           corrected_value);
                    mismatches++;
                end
                if (in_window !== want.win) begin
                    $error("in_window: expected %0d, got %0d", want.win, in_window);
                    mismatches++;
                end
                if (pixel_position !== want.pos) begin
                    $error("pixel_position: expected %0d, got %0d", want.pos,
                           pixel_position);
                    mismatches++;
                end
                if (line_done !== want.done) begin
                    $error("line_done: expected %0d, got %0d", want.done, line_done);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed table, then a series of register
    // settings, each followed by random traffic suited to it.
    initial begin
        int unsigned len;
        int unsigned a;
        int unsigned b;
        pixel_out_t none;
        none = '{default: '0};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed[i])
            send_pixel(directed[i].op, directed[i].pix, directed[i].le, directed[i].typed,
                       directed[i].has_res, directed[i].res);
        settle();

        // Shortest line: every pixel is a line of its own.
        configure(1, 0, 0, 0, 0);
        random_phase(120, 20, 0);
        settle();

        // Zero length acts as one; reversed overscan window gives no samples.
        configure(0, 5, 2, 2047, 2047);
        random_phase(60, 20, 30);
        settle();

        // Long line with no end marks. The overscan window at its end holds
        // 40 samples.
        configure(500, 460, 499, 0, 459);
        for (int i = 0; i < 500; i++)
            send_pixel(OP_STORE, rand_pixel(), 1'b0, 0, 0, none);
        for (int i = 0; i < 502; i++)
            send_pixel(($urandom_range(0, 9) == 0) ? OP_STORE : OP_DRAIN, rand_pixel(),
                       1'b0, 0, 0, none);
        settle();

        // Out-of-range length saturates to the store size; the overscan
        // window spans whole lines, so the sample store fills at 64.
        configure(4095, 0, 2047, 0, 2047);
        random_phase(150, 10, 1);
        settle();

        // Short lines with random windows, some of them reversed.
        for (int ph = 0; ph < 6; ph++) begin
            len = $urandom_range(1, 40);
            a = $urandom_range(0, len + 2);
            b = $urandom_range(0, len + 2);
            if (ph % 3 == 0)
                configure(len, a, b, b, a);
            else
                configure(len, (a < b) ? a : b, (a < b) ? b : a, $urandom_range(0, len),
                          $urandom_range(0, len + 2));
            random_phase(75, 15, 5);
            settle();
        end

        // Pixels accepted with the line length at the store size and every window register at its top value.
        configure(2048, 2047, 2047, 2047, 2047);
        random_phase(40, 10, 40);

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("overscan_median_subtract: match");
        else
            $display("overscan_median_subtract: mismatch");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(30_000_000);
        $display("overscan_median_subtract: mismatch");
        $finish;
    end

endmodule
